@@ rtl/usmeg_pkg.sv @@
// Shared widths, element kind codes and transfer types of the UV sphere element generator.
`timescale 1ns / 1ps
`default_nettype none
package usmeg_pkg;

  localparam int IDX_W  = 25;   // global index
  localparam int M_W    = 13;   // points per ring (nu-1)
  localparam int NVP_W  = 14;   // latitude count plus one
  localparam int MNV_W  = 26;   // points on all rings
  localparam int CRN_W  = 24;   // corner vertex number
  localparam int CORD_W = 34;   // CORDIC datapath
  localparam int KIND_W = 3;

  localparam logic [KIND_W-1:0] KIND_ERR   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RING  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SOUTH = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NORTH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOW   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_UP    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SCAP  = 3'd6;
  localparam logic [KIND_W-1:0] KIND_NCAP  = 3'd7;

  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // One classified transaction waiting between front and back.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
  } cls_t;

  // Kind and face corners that ride along the back pipeline.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CRN_W-1:0]  ca;
    logic [CRN_W-1:0]  cb;
    logic [CRN_W-1:0]  cc;
  } carry_t;

  // Mesh sizes derived from the configuration registers.
  typedef struct packed {
    logic [M_W-1:0]   m;
    logic [NVP_W-1:0] nvp1;
    logic [MNV_W-1:0] mnv;
  } dcfg_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
  } cord_t;

endpackage
`default_nettype wire

@@ rtl/usmeg_queue.sv @@
// Short queue of classified transactions between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module usmeg_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  usmeg_pkg::cls_t     push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output usmeg_pkg::cls_t     pop_data
);
  import usmeg_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  cls_t mem [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W+1)'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/usmeg_front.sv @@
// Front end: input register and classification of each index into an element kind.
`timescale 1ns / 1ps
`default_nettype none
module usmeg_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               cmd,
  input  wire logic [24:0]        global_index,
  input  usmeg_pkg::dcfg_t        dcfg,
  output logic                    push,
  output usmeg_pkg::cls_t         push_data,
  input  wire logic               q_full
);
  import usmeg_pkg::*;

  localparam logic CMD_VERTEX = 1'b0;

  logic             f_valid;
  logic             f_cmd;
  logic [IDX_W-1:0] f_idx;

  assign in_stall = f_valid & q_full;
  assign push     = f_valid & ~q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!in_stall) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      f_cmd <= cmd;
      f_idx <= global_index;
    end
  end

  // Vertices: ring points, then south pole, then north pole.
  // Faces: lower band, upper band, south cap, north cap.
  always_comb begin
    logic [MNV_W:0] g;
    logic [MNV_W:0] mnv;
    logic [MNV_W:0] mm;
    logic [MNV_W:0] nf;
    g   = (MNV_W+1)'(f_idx);
    mnv = (MNV_W+1)'(dcfg.mnv);
    mm  = (MNV_W+1)'(dcfg.m);
    nf  = {dcfg.mnv, 1'b0};
    push_data.kind = KIND_ERR;
    push_data.idx  = '0;
    if (f_cmd == CMD_VERTEX) begin
      if (g >= mnv + (MNV_W+1)'(2)) begin
        push_data.kind = KIND_ERR;
      end else if (g == mnv + (MNV_W+1)'(1)) begin
        push_data.kind = KIND_NORTH;
      end else if (g == mnv) begin
        push_data.kind = KIND_SOUTH;
      end else begin
        push_data.kind = KIND_RING;
        push_data.idx  = f_idx;
      end
    end else begin
      if (g >= nf) begin
        push_data.kind = KIND_ERR;
      end else if (g >= nf - mm) begin
        push_data.kind = KIND_NCAP;
        push_data.idx  = IDX_W'(g - (nf - mm));
      end else if (g >= nf - {mm[MNV_W-1:0], 1'b0}) begin
        push_data.kind = KIND_SCAP;
        push_data.idx  = IDX_W'(g - (nf - {mm[MNV_W-1:0], 1'b0}));
      end else if (g >= mnv - mm) begin
        push_data.kind = KIND_UP;
        push_data.idx  = IDX_W'(g - (mnv - mm));
      end else begin
        push_data.kind = KIND_LOW;
        push_data.idx  = f_idx;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/usmeg_back.sv @@
// Back end: pipelined index divider, phase dividers, CORDIC and coordinate scaling.
`timescale 1ns / 1ps
`default_nettype none
module usmeg_back #(
  parameter int TRIG_ITERATIONS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  usmeg_pkg::dcfg_t        dcfg,
  input  wire logic signed [31:0] center_x,
  input  wire logic signed [31:0] center_y,
  input  wire logic signed [31:0] center_z,
  input  wire logic [30:0]        sphere_radius,
  input  wire logic               q_valid,
  input  usmeg_pkg::cls_t         q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      coord_x,
  output logic signed [31:0]      coord_y,
  output logic signed [31:0]      coord_z,
  output logic [23:0]             corner_a,
  output logic [23:0]             corner_b,
  output logic [23:0]             corner_c,
  output logic                    index_error
);
  import usmeg_pkg::*;

  localparam int A_N = IDX_W;
  localparam int B_N = 32;
  localparam int C_OFS = A_N + 1 + B_N + 1;
  localparam int E_OFS = C_OFS + TRIG_ITERATIONS + 1;
  localparam int L = E_OFS + 5;

  function automatic logic signed [CORD_W-1:0] atan_turn(input int k);
    case (k)
      0: return CORD_W'(536870912);   1: return CORD_W'(316933406);
      2: return CORD_W'(167458907);   3: return CORD_W'(85004756);
      4: return CORD_W'(42667331);    5: return CORD_W'(21354465);
      6: return CORD_W'(10679838);    7: return CORD_W'(5340245);
      8: return CORD_W'(2670163);     9: return CORD_W'(1335087);
      10: return CORD_W'(667544);     11: return CORD_W'(333772);
      12: return CORD_W'(166886);     13: return CORD_W'(83443);
      14: return CORD_W'(41722);      15: return CORD_W'(20861);
      16: return CORD_W'(10430);      17: return CORD_W'(5215);
      18: return CORD_W'(2608);       19: return CORD_W'(1304);
      20: return CORD_W'(652);        21: return CORD_W'(326);
      22: return CORD_W'(163);        23: return CORD_W'(81);
      24: return CORD_W'(41);         25: return CORD_W'(20);
      26: return CORD_W'(10);         27: return CORD_W'(5);
      28: return CORD_W'(3);          29: return CORD_W'(1);
      30: return CORD_W'(1);
      default: return '0;
    endcase
  endfunction

  function automatic cord_t cord_step(input cord_t c, input int k);
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;
    cord_t r;
    x  = c.x;
    y  = c.y;
    z  = c.z;
    dx = y >>> k;
    dy = x >>> k;
    if (!z[CORD_W-1]) begin
      r.x = x - dx;
      r.y = y + dy;
      r.z = z - atan_turn(k);
    end else begin
      r.x = x + dx;
      r.y = y - dy;
      r.z = z + atan_turn(k);
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  logic         adv;
  logic [L-1:0] vld;

  assign out_valid = vld[L-1];
  assign adv       = ~(vld[L-1] & out_stall);
  assign q_pop     = adv & q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], q_pop};
    end
  end

  // Index divider: h / m, one quotient bit per stage.
  logic [M_W-1:0]   a_rem [0:A_N];
  logic [IDX_W-1:0] a_n   [0:A_N];
  carry_t           a_car [0:A_N];

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rem[0]      <= '0;
      a_n[0]        <= q_data.idx;
      a_car[0].kind <= q_data.kind;
      a_car[0].ca   <= '0;
      a_car[0].cb   <= '0;
      a_car[0].cc   <= '0;
    end
  end

  for (genvar k = 0; k < A_N; k++) begin : g_adiv
    logic [M_W:0] t;
    logic         ge;
    assign t  = {a_rem[k], a_n[k][IDX_W-1]};
    assign ge = (t >= {1'b0, dcfg.m});
    always_ff @(posedge clk) begin
      if (adv) begin
        a_rem[k+1] <= ge ? M_W'(t - {1'b0, dcfg.m}) : t[M_W-1:0];
        a_n[k+1]   <= {a_n[k][IDX_W-2:0], ge};
        a_car[k+1] <= a_car[k];
      end
    end
  end

  // Phase dividers: longitude ii*2^32/m and latitude (jj+1)*2^31/(nv+1), rounded.
  logic [M_W-1:0]   b_ru  [0:B_N];
  logic [31:0]      b_lu  [0:B_N];
  logic [NVP_W-1:0] b_rv  [0:B_N];
  logic [31:0]      b_lv  [0:B_N];
  carry_t           b_car [0:B_N];
  logic [M_W-1:0]   b0_ii;
  logic [MNV_W-1:0] b0_mj;
  logic [NVP_W-1:0] jp1;

  assign jp1 = {1'b0, a_n[A_N][M_W-1:0]} + NVP_W'(1);

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ru[0]  <= a_rem[A_N];
      b_lu[0]  <= 32'(dcfg.m >> 1);
      b_rv[0]  <= {1'b0, jp1[NVP_W-1:1]};
      b_lv[0]  <= {jp1[0], 31'(dcfg.nvp1 >> 1)};
      b_car[0] <= a_car[A_N];
      b0_ii    <= a_rem[A_N];
      b0_mj    <= dcfg.m * a_n[A_N][M_W-1:0];
    end
  end

  for (genvar k = 0; k < B_N; k++) begin : g_bdiv
    logic [M_W:0]   tu;
    logic [NVP_W:0] tv;
    logic           geu;
    logic           gev;
    assign tu  = {b_ru[k], b_lu[k][31]};
    assign tv  = {b_rv[k], b_lv[k][31]};
    assign geu = (tu >= {1'b0, dcfg.m});
    assign gev = (tv >= {1'b0, dcfg.nvp1});
    always_ff @(posedge clk) begin
      if (adv) begin
        b_ru[k+1] <= geu ? M_W'(tu - {1'b0, dcfg.m}) : tu[M_W-1:0];
        b_lu[k+1] <= {b_lu[k][30:0], geu};
        b_rv[k+1] <= gev ? NVP_W'(tv - {1'b0, dcfg.nvp1}) : tv[NVP_W-1:0];
        b_lv[k+1] <= {b_lv[k][30:0], gev};
      end
    end
    if (k == 0) begin : g_corner
      // Face corners from ring position ii and ring base m*jj.
      carry_t cn;
      always_comb begin
        logic [MNV_W:0] ii;
        logic [MNV_W:0] wr;
        logic [MNV_W:0] mj;
        logic [MNV_W:0] mm;
        logic [MNV_W:0] mnv;
        logic [MNV_W:0] bi;
        logic [MNV_W:0] bw;
        logic [MNV_W:0] band;
        ii   = (MNV_W+1)'(b0_ii);
        mm   = (MNV_W+1)'(dcfg.m);
        wr   = (ii + (MNV_W+1)'(1) == mm) ? '0 : ii + (MNV_W+1)'(1);
        mj   = (MNV_W+1)'(b0_mj);
        mnv  = (MNV_W+1)'(dcfg.mnv);
        bi   = (MNV_W+1)'(1) + ii + mj;
        bw   = (MNV_W+1)'(1) + wr + mj;
        band = mnv - mm;
        cn.kind = b_car[0].kind;
        cn.ca   = '0;
        cn.cb   = '0;
        cn.cc   = '0;
        case (b_car[0].kind)
          KIND_LOW: begin
            cn.ca = CRN_W'(bi);
            cn.cb = CRN_W'(bw);
            cn.cc = CRN_W'(bi + mm);
          end
          KIND_UP: begin
            cn.ca = CRN_W'(bw);
            cn.cb = CRN_W'(bw + mm);
            cn.cc = CRN_W'(bi + mm);
          end
          KIND_SCAP: begin
            cn.ca = CRN_W'((MNV_W+1)'(1) + ii);
            cn.cb = CRN_W'(mnv + (MNV_W+1)'(1));
            cn.cc = CRN_W'((MNV_W+1)'(1) + wr);
          end
          KIND_NCAP: begin
            cn.ca = CRN_W'((MNV_W+1)'(1) + ii + band);
            cn.cb = CRN_W'((MNV_W+1)'(1) + wr + band);
            cn.cc = CRN_W'(mnv + (MNV_W+1)'(2));
          end
          default: begin
            cn.ca = '0;
          end
        endcase
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          b_car[k+1] <= cn;
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (adv) begin
          b_car[k+1] <= b_car[k];
        end
      end
    end
  end

  // Quadrant reduction and CORDIC rotations for longitude and latitude.
  cord_t      c_u   [0:TRIG_ITERATIONS];
  cord_t      c_v   [0:TRIG_ITERATIONS];
  logic [1:0] c_qu  [0:TRIG_ITERATIONS];
  logic [1:0] c_qv  [0:TRIG_ITERATIONS];
  carry_t     c_car [0:TRIG_ITERATIONS];

  logic [1:0]  qu;
  logic [1:0]  qv;
  logic [31:0] ru;
  logic [31:0] rv;
  logic [31:0] vph;
  logic [31:0] su_ph;
  logic [31:0] sv_ph;

  assign vph   = b_lv[B_N] - 32'h4000_0000;
  assign su_ph = b_lu[B_N] + 32'h2000_0000;
  assign sv_ph = vph + 32'h2000_0000;
  assign qu    = su_ph[31:30];
  assign qv    = sv_ph[31:30];
  assign ru    = b_lu[B_N] - {qu, 30'd0};
  assign rv    = vph - {qv, 30'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      c_u[0].x <= CORDIC_GAIN;
      c_u[0].y <= '0;
      c_u[0].z <= {{(CORD_W-32){ru[31]}}, ru};
      c_v[0].x <= CORDIC_GAIN;
      c_v[0].y <= '0;
      c_v[0].z <= {{(CORD_W-32){rv[31]}}, rv};
      c_qu[0]  <= qu;
      c_qv[0]  <= qv;
      c_car[0] <= b_car[B_N];
    end
  end

  for (genvar k = 0; k < TRIG_ITERATIONS; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        c_u[k+1]   <= cord_step(c_u[k], k);
        c_v[k+1]   <= cord_step(c_v[k], k);
        c_qu[k+1]  <= c_qu[k];
        c_qv[k+1]  <= c_qv[k];
        c_car[k+1] <= c_car[k];
      end
    end
  end

  // Map the rotated vector back to its quadrant.
  logic signed [31:0] cu_n;
  logic signed [31:0] su_n;
  logic signed [31:0] cv_n;
  logic signed [31:0] sv_n;

  always_comb begin
    logic signed [CORD_W-1:0] xu;
    logic signed [CORD_W-1:0] yu;
    logic signed [CORD_W-1:0] xv;
    logic signed [CORD_W-1:0] yv;
    xu = c_u[TRIG_ITERATIONS].x;
    yu = c_u[TRIG_ITERATIONS].y;
    xv = c_v[TRIG_ITERATIONS].x;
    yv = c_v[TRIG_ITERATIONS].y;
    case (c_qu[TRIG_ITERATIONS])
      2'd0:    begin cu_n = xu[31:0];      su_n = yu[31:0];      end
      2'd1:    begin cu_n = -yu[31:0];     su_n = xu[31:0];      end
      2'd2:    begin cu_n = -xu[31:0];     su_n = -yu[31:0];     end
      default: begin cu_n = yu[31:0];      su_n = -xu[31:0];     end
    endcase
    case (c_qv[TRIG_ITERATIONS])
      2'd0:    begin cv_n = xv[31:0];      sv_n = yv[31:0];      end
      2'd1:    begin cv_n = -yv[31:0];     sv_n = xv[31:0];      end
      2'd2:    begin cv_n = -xv[31:0];     sv_n = -yv[31:0];     end
      default: begin cv_n = yv[31:0];      sv_n = -xv[31:0];     end
    endcase
  end

  logic signed [31:0] e_cu;
  logic signed [31:0] e_su;
  logic signed [31:0] e_cv;
  logic signed [31:0] e_sv;
  carry_t             e0_car;
  logic signed [63:0] p_x;
  logic signed [63:0] p_y;
  logic signed [31:0] e1_sv;
  carry_t             e1_car;
  logic signed [31:0] f_x;
  logic signed [31:0] f_y;
  logic signed [31:0] f_z;
  carry_t             e2_car;
  logic signed [63:0] r_x;
  logic signed [63:0] r_y;
  logic signed [63:0] r_z;
  carry_t             e3_car;

  logic signed [63:0] rnd_x;
  logic signed [63:0] rnd_y;
  logic signed [31:0] rad;
  logic signed [63:0] o_x;
  logic signed [63:0] o_y;
  logic signed [63:0] o_z;

  assign rnd_x = p_x + 64'sd536870912;
  assign rnd_y = p_y + 64'sd536870912;
  assign rad   = $signed({1'b0, sphere_radius});
  assign o_x   = $signed({{32{center_x[31]}}, center_x}) + ((r_x + 64'sd536870912) >>> 30);
  assign o_y   = $signed({{32{center_y[31]}}, center_y}) + ((r_y + 64'sd536870912) >>> 30);
  assign o_z   = $signed({{32{center_z[31]}}, center_z}) + ((r_z + 64'sd536870912) >>> 30);

  always_ff @(posedge clk) begin
    if (adv) begin
      e_cu   <= cu_n;
      e_su   <= su_n;
      e_cv   <= cv_n;
      e_sv   <= sv_n;
      e0_car <= c_car[TRIG_ITERATIONS];

      p_x    <= e_cv * e_cu;
      p_y    <= e_cv * e_su;
      e1_sv  <= e_sv;
      e1_car <= e0_car;

      // Poles reuse the scaling path with a unit factor on z.
      case (e1_car.kind)
        KIND_RING: begin
          f_x <= rnd_x[61:30];
          f_y <= rnd_y[61:30];
          f_z <= e1_sv;
        end
        KIND_SOUTH: begin
          f_x <= '0;
          f_y <= '0;
          f_z <= -32'sd1073741824;
        end
        KIND_NORTH: begin
          f_x <= '0;
          f_y <= '0;
          f_z <= 32'sd1073741824;
        end
        default: begin
          f_x <= '0;
          f_y <= '0;
          f_z <= '0;
        end
      endcase
      e2_car <= e1_car;

      r_x    <= rad * f_x;
      r_y    <= rad * f_y;
      r_z    <= rad * f_z;
      e3_car <= e2_car;

      if (e3_car.kind inside {KIND_RING, KIND_SOUTH, KIND_NORTH}) begin
        coord_x <= sat32(o_x);
        coord_y <= sat32(o_y);
        coord_z <= sat32(o_z);
      end else begin
        coord_x <= '0;
        coord_y <= '0;
        coord_z <= '0;
      end
      if (e3_car.kind inside {KIND_LOW, KIND_UP, KIND_SCAP, KIND_NCAP}) begin
        corner_a <= e3_car.ca;
        corner_b <= e3_car.cb;
        corner_c <= e3_car.cc;
      end else begin
        corner_a <= '0;
        corner_b <= '0;
        corner_c <= '0;
      end
      index_error <= (e3_car.kind == KIND_ERR);
    end
  end

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst) !adv |=> $stable(vld))
    else $error("back pipeline moved while held");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> coord_x == 0 && coord_z == 0 && corner_a == 0)
    else $error("error result carries data");

  a_face_no_coord: assert property (@(posedge clk) disable iff (rst)
    out_valid && corner_a != 0 |-> coord_x == 0 && coord_y == 0 && coord_z == 0
                                   && !index_error)
    else $error("face result carries coordinates");

endmodule
`default_nettype wire

@@ rtl/uv_sphere_mesh_element_generator.sv @@
// Top level of the UV sphere element generator: configuration registers and block wiring.
`timescale 1ns / 1ps
`default_nettype none
// Each input transaction carries a command (vertex or face) and a zero-based global index and
// produces exactly one result transaction. A vertex result gives the Q16.16 point on a UV
// sphere: rings of nu-1 points at nv latitudes from south to north, then the south pole and
// the north pole. A face result gives three 1-based vertex numbers, ordered lower band
// triangles, upper band triangles, south cap, north cap. An index past the vertex or face
// count raises index_error with all other fields zero. The block sustains one transaction
// per clock while out_stall does not hold a result. A result passes in order through the
// front register, the queue whose read loads the index divider, 25 quotient stages of that
// divider, 33 stages of the phase divider pair, TRIG_ITERATIONS + 1 CORDIC stages and five
// stages of quadrant mapping, multiplication, rounding and saturation, the last of which is
// the output register. While out_stall holds a result, the back pipeline waits and the
// four-entry queue and the front register keep taking transactions until they fill.
// Configuration is written through a ready-always port and must only change while no
// transaction is in flight; ring counts outside their range are clamped to [2, MAX_RING_POINTS]
// and [2, MAX_LATITUDES], and writes to an unknown register index are ignored.
module uv_sphere_mesh_element_generator #(
  parameter int MAX_RING_POINTS = 4096,
  parameter int MAX_LATITUDES   = 4096,
  parameter int TRIG_ITERATIONS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               cmd,
  input  wire logic [24:0]        global_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      coord_x,
  output logic signed [31:0]      coord_y,
  output logic signed [31:0]      coord_z,
  output logic [23:0]             corner_a,
  output logic [23:0]             corner_b,
  output logic [23:0]             corner_c,
  output logic                    index_error
);
  import usmeg_pkg::*;

  localparam logic [2:0] REG_NU     = 3'd0;
  localparam logic [2:0] REG_NV     = 3'd1;
  localparam logic [2:0] REG_CX     = 3'd2;
  localparam logic [2:0] REG_CY     = 3'd3;
  localparam logic [2:0] REG_CZ     = 3'd4;
  localparam logic [2:0] REG_RADIUS = 3'd5;

  logic [12:0]        ring_points_plus_one;
  logic [12:0]        latitude_rings;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        sphere_radius;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_points_plus_one <= 13'd17;
      latitude_rings       <= 13'd16;
      center_x             <= '0;
      center_y             <= '0;
      center_z             <= '0;
      sphere_radius        <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NU:     ring_points_plus_one <= cfg_data[12:0];
        REG_NV:     latitude_rings       <= cfg_data[12:0];
        REG_CX:     center_x             <= cfg_data;
        REG_CY:     center_y             <= cfg_data;
        REG_CZ:     center_z             <= cfg_data;
        REG_RADIUS: sphere_radius        <= cfg_data[30:0];
        default:    ;
      endcase
    end
  end

  // Clamped mesh sizes, registered in the cycle after a write. Classification works on the
  // front register, so an item accepted right after a write sees new sizes.
  logic [M_W-1:0] m_c;
  logic [12:0]    nv_c;
  dcfg_t          dcfg;

  always_comb begin
    if (ring_points_plus_one < 13'd2) begin
      m_c = M_W'(1);
    end else if (int'(ring_points_plus_one) > MAX_RING_POINTS) begin
      m_c = M_W'(MAX_RING_POINTS - 1);
    end else begin
      m_c = M_W'(ring_points_plus_one - 13'd1);
    end
    if (latitude_rings < 13'd2) begin
      nv_c = 13'd2;
    end else if (int'(latitude_rings) > MAX_LATITUDES) begin
      nv_c = 13'(MAX_LATITUDES);
    end else begin
      nv_c = latitude_rings;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcfg.m    <= M_W'(16);
      dcfg.nvp1 <= NVP_W'(17);
      dcfg.mnv  <= MNV_W'(256);
    end else begin
      dcfg.m    <= m_c;
      dcfg.nvp1 <= {1'b0, nv_c} + NVP_W'(1);
      dcfg.mnv  <= m_c * nv_c;
    end
  end

  logic  push;
  cls_t  push_data;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  cls_t  q_data;

  usmeg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .global_index (global_index),
    .dcfg         (dcfg),
    .push         (push),
    .push_data    (push_data),
    .q_full       (q_full)
  );

  usmeg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  usmeg_back #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .dcfg          (dcfg),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .sphere_radius (sphere_radius),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .coord_z       (coord_z),
    .corner_a      (corner_a),
    .corner_b      (corner_b),
    .corner_c      (corner_c),
    .index_error   (index_error)
  );

endmodule
`default_nettype wire

@@ sim/tb_uv_sphere_mesh_element_generator.sv @@
// Self-checking testbench of the UV sphere element generator with a built-in predictor.
`timescale 1ns / 1ps
`default_nettype none

// Holds the predicted sphere elements in order and compares each result against the oldest.
class sphere_element_board;
  logic [31:0] want_x[$], want_y[$], want_z[$];
  logic [23:0] want_a[$], want_b[$], want_c[$];
  logic        want_err[$];
  int          failures = 0;

  function void note_element(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [23:0] a, logic [23:0] b, logic [23:0] c, logic e);
    want_x.push_back(x); want_y.push_back(y); want_z.push_back(z);
    want_a.push_back(a); want_b.push_back(b); want_c.push_back(c);
    want_err.push_back(e);
  endfunction

  function int pending();
    return want_x.size();
  endfunction

  function void check_element(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [23:0] a, logic [23:0] b, logic [23:0] c, logic e);
    logic [31:0] ex, ey, ez;
    logic [23:0] ea, eb, ec;
    logic        ee;
    if (want_x.size() == 0) begin
      $display("%0t: unexpected result x=%h y=%h z=%h a=%0d b=%0d c=%0d err=%b",
               $time, x, y, z, a, b, c, e);
      failures++;
      return;
    end
    ex = want_x.pop_front(); ey = want_y.pop_front(); ez = want_z.pop_front();
    ea = want_a.pop_front(); eb = want_b.pop_front(); ec = want_c.pop_front();
    ee = want_err.pop_front();
    if (x !== ex) begin $display("%0t: coord_x expected %h actual %h", $time, ex, x);
      failures++; end
    if (y !== ey) begin $display("%0t: coord_y expected %h actual %h", $time, ey, y);
      failures++; end
    if (z !== ez) begin $display("%0t: coord_z expected %h actual %h", $time, ez, z);
      failures++; end
    if (a !== ea) begin $display("%0t: corner_a expected %0d actual %0d", $time, ea, a);
      failures++; end
    if (b !== eb) begin $display("%0t: corner_b expected %0d actual %0d", $time, eb, b);
      failures++; end
    if (c !== ec) begin $display("%0t: corner_c expected %0d actual %0d", $time, ec, c);
      failures++; end
    if (e !== ee) begin $display("%0t: index_error expected %b actual %b", $time, ee, e);
      failures++; end
  endfunction
endclass

module tb_uv_sphere_mesh_element_generator;
  import usmeg_pkg::*;

  localparam int MAX_RP = 4096;
  localparam int MAX_LAT = 4096;
  localparam int N_ITER = 24;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_NU     = 3'd0;
  localparam logic [2:0] REG_NV     = 3'd1;
  localparam logic [2:0] REG_CX     = 3'd2;
  localparam logic [2:0] REG_CY     = 3'd3;
  localparam logic [2:0] REG_CZ     = 3'd4;
  localparam logic [2:0] REG_RADIUS = 3'd5;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // Commands.
  localparam logic CMD_VERTEX = 1'b0;
  localparam logic CMD_FACE   = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = 1'b0;
  logic [24:0] global_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] coord_x, coord_y, coord_z;
  logic [23:0] corner_a, corner_b, corner_c;
  logic index_error;

  always #6 clk = ~clk;

  uv_sphere_mesh_element_generator #(
    .MAX_RING_POINTS(MAX_RP), .MAX_LATITUDES(MAX_LAT), .TRIG_ITERATIONS(N_ITER)
  ) uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .global_index(global_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .index_error(index_error)
  );

  sphere_element_board board = new();

  // Predictor's copy of the configuration registers.
  logic [12:0] nu_reg = 13'd17;
  logic [12:0] nv_reg = 13'd16;
  logic signed [63:0] cx_reg = 0, cy_reg = 0, cz_reg = 0;
  logic signed [63:0] radius_reg = 65536;

  // Arctangent table in units of 2^-32 turn, one entry per CORDIC rotation.
  logic signed [63:0] atan_turn_tab [0:31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

  bit hold_off_busy = 0;
  int unsigned idle_cycles = 0;

  function automatic logic [31:0] saturate32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Round a Q2.30 product (half up) back to integer scale.
  function automatic logic signed [63:0] round30(logic signed [63:0] v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // CORDIC sine and cosine of a phase in turns, Q2.30.
  task automatic turn_sincos(input logic [31:0] ph, output logic signed [63:0] co,
                             output logic signed [63:0] si);
    logic [31:0] q, rr;
    logic signed [63:0] z, x, y, dx, dy;
    q = (ph + 32'h20000000) >> 30;
    rr = ph - (q << 30);
    z = $signed({{32{rr[31]}}, rr});
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < N_ITER; i++) begin
      dx = y >>> (i & 31);
      dy = x >>> (i & 31);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_turn_tab[i & 31];
      end else begin
        x += dx; y -= dy; z += atan_turn_tab[i & 31];
      end
    end
    case (q[1:0])
      2'd0: begin co = x; si = y; end
      2'd1: begin co = -y; si = x; end
      2'd2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endtask

  // Works out the element for one accepted transaction and notes it on the board.
  task automatic predict_element(input logic c, input logic [24:0] g25);
    longint unsigned nu, nv, m, n_vtx, n_face, g, band, jj, ii, h, a, b, cc;
    logic [31:0] uph, vph;
    logic signed [63:0] cu, su, cv, sv, px, py, pz;
    nu = nu_reg < 2 ? 2 : (nu_reg > MAX_RP ? MAX_RP : nu_reg);
    nv = nv_reg < 2 ? 2 : (nv_reg > MAX_LAT ? MAX_LAT : nv_reg);
    m = nu - 1;
    n_vtx = m * nv + 2;
    n_face = 2 * m * nv;
    g = g25;
    if (c == CMD_VERTEX) begin
      if (g >= n_vtx) begin
        board.note_element(0, 0, 0, 0, 0, 0, 1'b1);
        return;
      end
      if (g >= n_vtx - 2) begin
        px = cx_reg;
        py = cy_reg;
        pz = (g == n_vtx - 1) ? cz_reg + radius_reg : cz_reg - radius_reg;
      end else begin
        jj = g / m;
        ii = g % m;
        uph = 32'(((ii << 32) + m / 2) / m);
        vph = 32'((((jj + 1) << 31) + (nv + 1) / 2) / (nv + 1)) - 32'h40000000;
        turn_sincos(uph, cu, su);
        turn_sincos(vph, cv, sv);
        px = cx_reg + round30(radius_reg * round30(cv * cu));
        py = cy_reg + round30(radius_reg * round30(cv * su));
        pz = cz_reg + round30(radius_reg * sv);
      end
      board.note_element(saturate32(px), saturate32(py), saturate32(pz), 0, 0, 0, 1'b0);
    end else begin
      if (g >= n_face) begin
        board.note_element(0, 0, 0, 0, 0, 0, 1'b1);
        return;
      end
      band = m * (nv - 1);
      if (g >= 2 * band + m) begin
        // North cap fans around the north pole.
        ii = g - (2 * band + m);
        a = 1 + ii + band; b = 1 + (ii + 1) % m + band; cc = n_vtx;
      end else if (g >= 2 * band) begin
        // South cap fans around the south pole.
        ii = g - 2 * band;
        a = 1 + ii; b = n_vtx - 1; cc = 1 + (ii + 1) % m;
      end else if (g >= band) begin
        h = g - band; jj = h / m; ii = h % m;
        a = 1 + (ii + 1) % m + m * jj; b = 1 + (ii + 1) % m + m * (jj + 1);
        cc = 1 + ii + m * (jj + 1);
      end else begin
        jj = g / m; ii = g % m;
        a = 1 + ii + m * jj; b = 1 + (ii + 1) % m + m * jj; cc = 1 + ii + m * (jj + 1);
      end
      board.note_element(0, 0, 0, a[23:0], b[23:0], cc[23:0], 1'b0);
    end
  endtask

  // Writes one register through the configuration port and mirrors it in the predictor.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NU: nu_reg = val[12:0];
      REG_NV: nv_reg = val[12:0];
      REG_CX: cx_reg = $signed(val);
      REG_CY: cy_reg = $signed(val);
      REG_CZ: cz_reg = $signed(val);
      REG_RADIUS: radius_reg = {33'd0, val[30:0]};
      default: ;
    endcase
  endtask

  task automatic write_shape(input int nu, input int nv, input logic [31:0] cx,
                             input logic [31:0] cy, input logic [31:0] cz,
                             input logic [31:0] r);
    write_reg(REG_NU, nu);
    write_reg(REG_NV, nv);
    write_reg(REG_CX, cx);
    write_reg(REG_CY, cy);
    write_reg(REG_CZ, cz);
    write_reg(REG_RADIUS, r);
  endtask

  // Sends one transaction; the predictor runs once it is accepted.
  task automatic send_element(input logic c, input logic [24:0] g);
    in_valid <= 1'b1;
    cmd <= c;
    global_index <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_element(c, g);
  endtask

  // Random gap, mostly short, occasionally long; the valid is lowered only for a gap.
  task automatic sender_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 55) return;
    in_valid <= 1'b0;
    if (n < 95) repeat ($urandom_range(1, 3)) @(posedge clk);
    else repeat ($urandom_range(10, 40)) @(posedge clk);
  endtask

  // Wait until every element is back, then let the pipeline settle before a write.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Picks an index that lands on interesting ranges for the current mesh.
  function automatic logic [24:0] pick_index(input logic c);
    longint unsigned nu, nv, m, lim;
    int sel;
    nu = nu_reg < 2 ? 2 : (nu_reg > MAX_RP ? MAX_RP : nu_reg);
    nv = nv_reg < 2 ? 2 : (nv_reg > MAX_LAT ? MAX_LAT : nv_reg);
    m = nu - 1;
    lim = (c == CMD_VERTEX) ? m * nv + 2 : 2 * m * nv;
    sel = $urandom_range(0, 99);
    if (sel < 6) return 25'($urandom);                  // any pattern, mostly out of range
    if (sel < 12) return 25'(lim - 1 - $urandom_range(0, 2));
    if (sel < 16) return 25'(lim + $urandom_range(0, 2));
    if (sel < 26 && lim > 4) return 25'(lim - 1 - $urandom_range(0, 2 * m));
    return 25'({$urandom, $urandom} % lim);
  endfunction

  task automatic random_phase(input int count);
    logic c;
    for (int i = 0; i < count; i++) begin
      c = $urandom_range(0, 1);
      send_element(c, pick_index(c));
      sender_gap();
    end
  endtask

  // Receiver: random stalls, with one long hold-off while the sender keeps pushing.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_busy) begin
        out_stall <= 1'b1;
      end else begin
        n = $urandom_range(0, 99);
        out_stall <= (n < 25) || (n >= 98);
        if (n >= 98) repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  // Results are taken at each edge where valid is high and stall is low.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_element(coord_x, coord_y, coord_z, corner_a, corner_b, corner_c,
                          index_error);
  end

  // Watchdog on cycles with no accepted transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("uv_sphere_mesh_element_generator verification failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset shape first: poles, ring points, every face kind and both out-of-range edges.
    send_element(CMD_VERTEX, 0);
    send_element(CMD_VERTEX, 15);
    send_element(CMD_VERTEX, 16 * 16);
    send_element(CMD_VERTEX, 16 * 16 + 1);
    send_element(CMD_VERTEX, 16 * 16 + 2);
    send_element(CMD_VERTEX, 25'h1ffffff);
    send_element(CMD_FACE, 0);
    send_element(CMD_FACE, 15);
    send_element(CMD_FACE, 16 * 15);
    send_element(CMD_FACE, 2 * 16 * 15);
    send_element(CMD_FACE, 2 * 16 * 15 + 15);
    send_element(CMD_FACE, 2 * 16 * 15 + 16);
    send_element(CMD_FACE, 2 * 16 * 16 - 1);
    send_element(CMD_FACE, 2 * 16 * 16);
    send_element(CMD_FACE, 25'h1ffffff);
    drain();

    // Smallest mesh with ring counts below range, unknown register write ignored.
    write_shape(0, 1, 32'h7fff0000, 32'h80000000, 32'h00010000, 32'h7fffffff);
    write_reg(REG_UNUSED, 32'hffffffff);
    for (int g = 0; g < 4; g++) send_element(CMD_VERTEX, 25'(g));
    for (int g = 0; g < 5; g++) send_element(CMD_FACE, 25'(g));
    drain();

    // Long hold-off on the receiver while the sender keeps offering transactions, long
    // enough for the pipeline, the queue and the front register to fill.
    write_shape(33, 8, 32'h00030000, 32'hfffd0000, 32'h00001234, 32'h00028000);
    fork
      begin
        hold_off_busy = 1;
        repeat (600) @(posedge clk);
        hold_off_busy = 0;
      end
      random_phase(200);
    join
    random_phase(160);
    drain();

    // Largest mesh in range with saturating centers; then clamped counts above range.
    write_shape(4096, 4096, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    random_phase(200);
    drain();
    write_shape(8191, 8191, 32'hffffffff, 32'h00000001, 32'h80000000, 32'h00000000);
    random_phase(120);
    drain();

    // Mid-size random shapes.
    for (int p = 0; p < 4; p++) begin
      write_shape($urandom_range(2, 70), $urandom_range(2, 70), $urandom, $urandom,
                  $urandom, $urandom);
      random_phase(180);
      drain();
    end
    write_shape(17, 16, 0, 0, 0, 32'h00010000);
    random_phase(90);

    in_valid <= 1'b0;
    drain();
    if (board.failures == 0)
      $display("uv_sphere_mesh_element_generator verification clean");
    else
      $display("uv_sphere_mesh_element_generator verification failed");
    $finish;
  end

endmodule
`default_nettype wire
